>>> rtl/sle_pkg.sv
package sle_pkg;

  // Result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Special characters and scancode flags
  localparam logic [6:0] CH_ENTER     = 7'd10;
  localparam logic [6:0] CH_BACKSPACE = 7'd8;
  localparam logic [6:0] CH_ESCAPE    = 7'd27;
  localparam int unsigned RELEASE_BIT = 7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic in_ready;
    logic latch_in;
    logic load_echo;
    logic store_char;
    logic dec_count;
    logic clear_count;
    logic clr_idx;
    logic rd_en;
    logic load_line;
    logic load_end;
  } sle_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic in_release;
    logic in_bs;
    logic ch_enter;
    logic ch_bs;
    logic count_zero;
    logic line_full;
    logic idx_done;
    logic out_free;
  } sle_status_t;

  // US layout, set-1 make codes; unmapped keys give 0
  function automatic logic [6:0] keymap_lookup(input logic [6:0] code);
    logic [6:0] ch;
    ch = 7'd0;
    case (code)
      7'd1:  ch = CH_ESCAPE;
      7'd2:  ch = 7'd49;
      7'd3:  ch = 7'd50;
      7'd4:  ch = 7'd51;
      7'd5:  ch = 7'd52;
      7'd6:  ch = 7'd53;
      7'd7:  ch = 7'd54;
      7'd8:  ch = 7'd55;
      7'd9:  ch = 7'd56;
      7'd10: ch = 7'd57;
      7'd11: ch = 7'd48;
      7'd12: ch = 7'd45;
      7'd13: ch = 7'd61;
      7'd14: ch = CH_BACKSPACE;
      7'd15: ch = 7'd9;
      7'd16: ch = 7'd113;
      7'd17: ch = 7'd119;
      7'd18: ch = 7'd101;
      7'd19: ch = 7'd114;
      7'd20: ch = 7'd116;
      7'd21: ch = 7'd121;
      7'd22: ch = 7'd117;
      7'd23: ch = 7'd105;
      7'd24: ch = 7'd111;
      7'd25: ch = 7'd112;
      7'd26: ch = 7'd91;
      7'd27: ch = 7'd93;
      7'd28: ch = CH_ENTER;
      7'd30: ch = 7'd97;
      7'd31: ch = 7'd115;
      7'd32: ch = 7'd100;
      7'd33: ch = 7'd102;
      7'd34: ch = 7'd103;
      7'd35: ch = 7'd104;
      7'd36: ch = 7'd106;
      7'd37: ch = 7'd107;
      7'd38: ch = 7'd108;
      7'd39: ch = 7'd59;
      7'd40: ch = 7'd39;
      7'd41: ch = 7'd96;
      7'd43: ch = 7'd92;
      7'd44: ch = 7'd122;
      7'd45: ch = 7'd120;
      7'd46: ch = 7'd99;
      7'd47: ch = 7'd118;
      7'd48: ch = 7'd98;
      7'd49: ch = 7'd110;
      7'd50: ch = 7'd109;
      7'd51: ch = 7'd44;
      7'd52: ch = 7'd46;
      7'd53: ch = 7'd47;
      7'd55: ch = 7'd42;
      7'd57: ch = 7'd32;
      7'd74: ch = 7'd45;
      7'd78: ch = 7'd43;
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/sle_if.sv
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
endinterface

interface sle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] char_code;
  logic [5:0] line_length;
  logic       last;

  modport source (output valid, output kind, output char_code, output line_length,
                  output last, input ready);
  modport sink (input valid, input kind, input char_code, input line_length,
                input last, output ready);
endinterface

>>> rtl/scancode_line_editor.sv
// Keyboard line editor fed with raw set-1 scancodes, one per input word. Key
// releases are swallowed; make codes are translated with a fixed US layout and
// echoed. Backspace on an empty line is dropped, otherwise it removes the last
// character. Enter echoes a newline, replays the stored line one word per
// character and closes with a line-end word carrying the length; the last word
// of each keystroke has last set. An ordinary character on a line holding
// LINE_CAPACITY-1 characters is echoed and the line is discarded. The line store
// has one registered read port, so on Enter each character is read and then
// loaded into the output register. Output stalls hold the editor until the
// output register is free. The output register lets a new scancode be taken
// while the last word waits.
module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_word,
  sle_out_if.source out_word
);

  sle_cmd_t    cmd;
  sle_status_t status;

  sle_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  sle_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

>>> rtl/sle_ctrl.sv
module sle_ctrl
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sle_status_t status,
  output sle_cmd_t    cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ECHO = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LINE = 5'b01000,
    ST_END  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid && !status.in_release &&
            !(status.in_bs && status.count_zero)) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_ECHO;
        end
      end
      ST_ECHO: begin
        if (status.out_free) begin
          cmd.load_echo = 1'b1;
          if (status.ch_enter) begin
            cmd.clr_idx = 1'b1;
            state_nxt   = ST_RD;
          end else begin
            if (status.ch_bs) begin
              cmd.dec_count = 1'b1;
            end else if (status.line_full) begin
              cmd.clear_count = 1'b1;
            end else begin
              cmd.store_char = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        if (status.idx_done) begin
          state_nxt = ST_END;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_LINE;
        end
      end
      ST_LINE: begin
        if (status.out_free) begin
          cmd.load_line = 1'b1;
          state_nxt     = ST_RD;
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.load_end    = 1'b1;
          cmd.clear_count = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sle_datapath.sv
module sle_datapath
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sle_in_if.sink      in_word,
  sle_out_if.source   out_word,
  input  sle_cmd_t    cmd,
  output sle_status_t status
);

  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LINE_CAPACITY - 1);

  logic [6:0]       line_mem [LINE_CAPACITY];
  logic [6:0]       ch_r;
  logic [6:0]       rdata_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r;
  logic [6:0]       out_char_r;
  logic [5:0]       out_len_r;
  logic             out_last_r;
  logic [6:0]       in_ch;

  assign in_ch = keymap_lookup(in_word.scancode[6:0]);

  // Report status
  assign status.in_valid   = in_word.valid;
  assign status.in_release = in_word.scancode[RELEASE_BIT];
  assign status.in_bs      = (in_ch == CH_BACKSPACE);
  assign status.ch_enter   = (ch_r == CH_ENTER);
  assign status.ch_bs      = (ch_r == CH_BACKSPACE);
  assign status.count_zero = (count_r == '0);
  assign status.line_full  = (count_r == FULL_COUNT);
  assign status.idx_done   = (idx_r == count_r);
  assign status.out_free   = !out_valid_r || out_word.ready;

  // Drive the channels
  assign in_word.ready         = cmd.in_ready;
  assign out_word.valid        = out_valid_r;
  assign out_word.kind         = out_kind_r;
  assign out_word.char_code    = out_char_r;
  assign out_word.line_length  = out_len_r;
  assign out_word.last         = out_last_r;

  // Latch the translated character
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      ch_r <= in_ch;
    end
  end

  // Line store: write at the fill point, registered read at the index
  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      line_mem[count_r] <= ch_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= line_mem[idx_r];
    end
  end

  // Advance count and read index
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_count) begin
      count_nxt = '0;
    end else if (cmd.dec_count) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.store_char) begin
      count_nxt = count_r + 1'b1;
    end
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.load_line) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_echo || cmd.load_line || cmd.load_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (cmd.load_echo) begin
      out_kind_r <= KIND_ECHO;
      out_char_r <= ch_r;
      out_len_r  <= 6'd0;
      out_last_r <= (ch_r != CH_ENTER);
    end else if (cmd.load_line) begin
      out_kind_r <= KIND_LINE;
      out_char_r <= rdata_r;
      out_len_r  <= 6'd0;
      out_last_r <= 1'b0;
    end else if (cmd.load_end) begin
      out_kind_r <= KIND_END;
      out_char_r <= 7'd0;
      out_len_r  <= 6'(count_r);
      out_last_r <= 1'b1;
    end
  end

endmodule

>>> sim/tb_scancode_line_editor.sv
module tb_scancode_line_editor;
  import sle_pkg::*;

  localparam int LINE_CAP = 32;
  localparam int KEYSTROKE_TARGET = 450;
  localparam int IDLE_LIMIT = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRINT_CAP = 40;

  // Make codes that edit the line
  localparam logic [7:0] BS_CODE = 8'h0E;
  localparam logic [7:0] ENTER_CODE = 8'h1C;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_code;
    logic [5:0] line_length;
    logic       last;
  } key_word_t;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic [1:0] count;
    key_word_t  w0;
    key_word_t  w1;
  } script_row_t;

  localparam key_word_t NO_WORD = '0;

  logic clk = 1'b0;
  logic rst_n;

  sle_in_if key_in ();
  sle_out_if key_out ();

  scancode_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (key_in),
    .out_word(key_out)
  );

  // Predicted editor state
  logic [6:0] us_layout [128];
  logic [6:0] line_buf [LINE_CAP];
  int line_len = 0;

  key_word_t due_words[$];
  script_row_t key_script [23];
  int mismatches = 0;
  int keystrokes = 0;
  int idle_cycles = 0;
  int send_calm = 0;
  int take_calm = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic key_word_t word(input logic [1:0] kind, input logic [6:0] ch,
                                     input logic [5:0] len, input logic last);
    key_word_t w;
    w.kind = kind;
    w.char_code = ch;
    w.line_length = len;
    w.last = last;
    return w;
  endfunction

  function automatic script_row_t typed_row(input logic [7:0] code, input logic [1:0] n,
                                            input key_word_t w0, input key_word_t w1);
    script_row_t r;
    r.code = code;
    r.typed = 1'b1;
    r.count = n;
    r.w0 = w0;
    r.w1 = w1;
    return r;
  endfunction

  function automatic script_row_t free_row(input logic [7:0] code);
    script_row_t r;
    r = '0;
    r.code = code;
    return r;
  endfunction

  // Translate one scancode, edit the line and return the number of words it causes
  function automatic int apply_keystroke(input logic [7:0] code, input logic record);
    key_word_t words[$];
    key_word_t tail;
    logic [6:0] ch;
    int k;
    if (code[RELEASE_BIT]) return 0;
    ch = us_layout[code[6:0]];
    if (ch == CH_BACKSPACE && line_len == 0) return 0;
    words.push_back(word(KIND_ECHO, ch, 6'd0, 1'b0));
    if (ch == CH_ENTER) begin
      for (k = 0; k < line_len; k++)
        words.push_back(word(KIND_LINE, line_buf[k], 6'd0, 1'b0));
      words.push_back(word(KIND_END, 7'd0, 6'(line_len), 1'b0));
      line_len = 0;
    end else if (ch == CH_BACKSPACE) begin
      line_len--;
    end else if (line_len >= LINE_CAP - 1) begin
      // full line: drop everything, keep nothing of this key
      line_len = 0;
    end else begin
      line_buf[line_len] = ch;
      line_len++;
    end
    tail = words[words.size() - 1];
    tail.last = 1'b1;
    words[words.size() - 1] = tail;
    if (record) foreach (words[i]) due_words.push_back(words[i]);
    return words.size();
  endfunction

  task automatic flag_error(input string msg);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one scancode after a random gap, hold it until taken and count it
  task automatic send_code(input logic [7:0] code);
    int gap;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      send_calm = $urandom_range(10, 30);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
    if (gap > 0) begin
      key_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_in.valid <= 1'b1;
    key_in.scancode <= code;
    do @(posedge clk); while (key_in.ready !== 1'b1);
    keystrokes++;
  endtask

  task automatic press(input logic [7:0] code);
    send_code(code);
    void'(apply_keystroke(code, 1'b1));
  endtask

  // Stimulus
  initial begin
    logic [7:0] code;
    int reach;
    int n;
    int mode;
    rst_n <= 1'b0;
    key_in.valid <= 1'b0;
    key_in.scancode <= 8'h00;
    us_layout = '{
      7'd0, 7'd27, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
      7'd55, 7'd56, 7'd57, 7'd48, 7'd45, 7'd61, 7'd8, 7'd9,
      7'd113, 7'd119, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117, 7'd105,
      7'd111, 7'd112, 7'd91, 7'd93, 7'd10, 7'd0, 7'd97, 7'd115,
      7'd100, 7'd102, 7'd103, 7'd104, 7'd106, 7'd107, 7'd108, 7'd59,
      7'd39, 7'd96, 7'd0, 7'd92, 7'd122, 7'd120, 7'd99, 7'd118,
      7'd98, 7'd110, 7'd109, 7'd44, 7'd46, 7'd47, 7'd0, 7'd42,
      7'd0, 7'd32, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd45, 7'd0, 7'd0, 7'd0, 7'd43, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };
    key_script = '{
      // Enter on the empty line right after reset
      typed_row(ENTER_CODE, 2'd2, word(KIND_ECHO, CH_ENTER, 6'd0, 1'b0),
                word(KIND_END, 7'd0, 6'd0, 1'b1)),
      // releases, lowest and highest
      typed_row(8'h80, 2'd0, NO_WORD, NO_WORD),
      typed_row(8'hFF, 2'd0, NO_WORD, NO_WORD),
      // backspace with nothing to erase
      typed_row(BS_CODE, 2'd0, NO_WORD, NO_WORD),
      // unmapped keys at both ends echo and store a zero
      typed_row(8'h00, 2'd1, word(KIND_ECHO, 7'd0, 6'd0, 1'b1), NO_WORD),
      typed_row(8'h7F, 2'd1, word(KIND_ECHO, 7'd0, 6'd0, 1'b1), NO_WORD),
      typed_row(BS_CODE, 2'd1, word(KIND_ECHO, CH_BACKSPACE, 6'd0, 1'b1), NO_WORD),
      free_row(8'h01),
      free_row(8'h10),
      free_row(8'h39),
      free_row(8'h02),
      typed_row(8'h9E, 2'd0, NO_WORD, NO_WORD),
      free_row(8'h0F),
      free_row(8'h4A),
      free_row(8'h4E),
      free_row(8'h37),
      free_row(ENTER_CODE),
      typed_row(BS_CODE, 2'd0, NO_WORD, NO_WORD),
      free_row(8'h1E),
      typed_row(BS_CODE, 2'd1, word(KIND_ECHO, CH_BACKSPACE, 6'd0, 1'b1), NO_WORD),
      typed_row(BS_CODE, 2'd0, NO_WORD, NO_WORD),
      typed_row(ENTER_CODE, 2'd2, word(KIND_ECHO, CH_ENTER, 6'd0, 1'b0),
                word(KIND_END, 7'd0, 6'd0, 1'b1)),
      free_row(8'h2B)
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed script
    foreach (key_script[i]) begin
      send_code(key_script[i].code);
      if (key_script[i].typed) begin
        void'(apply_keystroke(key_script[i].code, 1'b0));
        if (key_script[i].count > 0) due_words.push_back(key_script[i].w0);
        if (key_script[i].count > 1) due_words.push_back(key_script[i].w1);
      end else begin
        void'(apply_keystroke(key_script[i].code, 1'b1));
      end
    end

    // Random sessions, mostly whole lines closed by Enter
    while (keystrokes < KEYSTROKE_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        n = $urandom_range(0, 7);
        if (n < 2) reach = $urandom_range(29, 33);
        else if (n == 2) reach = $urandom_range(34, 45);
        else reach = $urandom_range(0, 20);
        for (int j = 0; j < reach; j++) begin
          if (reach < 25 && $urandom_range(0, 9) == 0) press(BS_CODE);
          if ($urandom_range(0, 9) == 0) begin
            code = 8'($urandom_range(0, 127));
            code[RELEASE_BIT] = 1'b1;
            press(code);
          end
          do code = 8'($urandom_range(0, 127));
          while (code == BS_CODE || code == ENTER_CODE);
          press(code);
        end
        press(ENTER_CODE);
      end else if (mode <= 7) begin
        n = $urandom_range(1, 8);
        repeat (n) press(8'($urandom_range(0, 255)));
      end else if (mode == 8) begin
        n = $urandom_range(1, 5);
        repeat (n) press(BS_CODE);
      end else begin
        press(ENTER_CODE);
      end
    end
    key_in.valid <= 1'b0;

    // Drain outstanding words, then watch for strays
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS scancode_line_editor");
    else $display("FAIL scancode_line_editor");
    $finish;
  end

  // Take result words with random stalls and check each against the oldest expectation
  initial begin
    key_word_t got;
    key_word_t want;
    int stall;
    key_out.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (take_calm > 0) begin
        take_calm--;
        stall = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        take_calm = $urandom_range(10, 30);
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        key_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      key_out.ready <= 1'b1;
      do @(posedge clk); while (key_out.valid !== 1'b1);
      got = word(key_out.kind, key_out.char_code, key_out.line_length, key_out.last);
      if (due_words.size() == 0) begin
        flag_error($sformatf("unexpected word kind %0d char %0d len %0d last %0d",
                             got.kind, got.char_code, got.line_length, got.last));
      end else begin
        want = due_words.pop_front();
        if (got.kind !== want.kind)
          flag_error($sformatf("kind %0d, want %0d", got.kind, want.kind));
        if (got.char_code !== want.char_code)
          flag_error($sformatf("char_code %0d, want %0d", got.char_code, want.char_code));
        if (got.line_length !== want.line_length)
          flag_error($sformatf("line_length %0d, want %0d", got.line_length,
                               want.line_length));
        if (got.last !== want.last)
          flag_error($sformatf("last %0d, want %0d", got.last, want.last));
      end
    end
  end

  // Stop a hung run: count cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (key_in.valid && key_in.ready) || (key_out.valid && key_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL scancode_line_editor");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
